// ----- rtl/core/msc_pkg.sv -----
package msc_pkg;

    localparam int VALUE_W     = 14;
    localparam int DWELL_W     = 16;
    localparam int SCANS_W     = 8;
    localparam int SEG_W       = 8;
    localparam int EN_W        = 4;
    localparam int BCD_DIGITS  = 4;
    localparam int WEIGHT_W    = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 14'd9999;

    localparam logic [CFG_INDEX_W-1:0] REG_DWELL_TICKS     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCANS_PER_VALUE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WRAP_VALUE      = 2'd2;

    localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd500;
    localparam logic [SCANS_W-1:0] SCANS_RESET = 8'd10;
    localparam logic [VALUE_W-1:0] WRAP_RESET  = 14'd9999;

    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_wr_t;

    typedef struct packed {
        logic advance;
    } cmd_t;

    typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

    function automatic logic [SEG_W-1:0] seg_font(input logic [3:0] digit);
        logic [SEG_W-1:0] pattern;
        unique case (digit)
            4'd0:    pattern = 8'b11111100;
            4'd1:    pattern = 8'b01100000;
            4'd2:    pattern = 8'b11011010;
            4'd3:    pattern = 8'b11110010;
            4'd4:    pattern = 8'b01100110;
            4'd5:    pattern = 8'b10110110;
            4'd6:    pattern = 8'b10111110;
            4'd7:    pattern = 8'b11100000;
            4'd8:    pattern = 8'b11111110;
            4'd9:    pattern = 8'b11110110;
            default: pattern = 8'b11111100;
        endcase
        return pattern;
    endfunction

endpackage

// ----- rtl/core/msc_front.sv -----
module msc_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           s_tick,
    output logic           q_valid,
    input  logic           q_ready,
    output msc_pkg::cmd_t  q_cmd
);

    msc_pkg::cmd_t queue_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          push;
    logic          pop;
    msc_pkg::cmd_t cmd_in;

    assign s_tready       = (count_reg != 2'd2);
    assign q_valid        = (count_reg != 2'd0);
    assign q_cmd          = queue_reg[rd_ptr_reg];
    assign push           = s_tvalid && s_tready;
    assign pop            = q_valid && q_ready;
    assign cmd_in.advance = s_tick;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ----- rtl/core/msc_back.sv -----
module msc_back #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  msc_pkg::cfg_wr_t               cfg,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  msc_pkg::cmd_t                  q_cmd,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [msc_pkg::SEG_W-1:0]      segments,
    output logic [msc_pkg::EN_W-1:0]       digit_enable_n,
    output logic [msc_pkg::VALUE_W-1:0]    shown_value
);

    localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    logic [msc_pkg::DWELL_W-1:0] dwell_ticks_reg;
    logic [msc_pkg::SCANS_W-1:0] scans_reg;
    logic [msc_pkg::VALUE_W-1:0] wrap_reg;

    logic [msc_pkg::VALUE_W-1:0] value_reg, value_next;
    msc_pkg::bcd_t               bcd_reg, bcd_next, bcd_inc;
    logic [POS_W-1:0]            pos_reg, pos_next;
    logic [msc_pkg::DWELL_W-1:0] dwell_cnt_reg, dwell_cnt_next;
    logic [msc_pkg::SCANS_W-1:0] scan_cnt_reg, scan_cnt_next;

    logic                        out_valid_reg;
    logic [msc_pkg::SEG_W-1:0]   seg_reg, seg_next;
    logic [msc_pkg::EN_W-1:0]    en_reg, en_next;
    logic [msc_pkg::VALUE_W-1:0] shown_reg;

    logic [msc_pkg::DWELL_W-1:0] dwell_eff, dwell_inc;
    logic [msc_pkg::SCANS_W-1:0] scans_eff, scan_inc;
    logic [msc_pkg::VALUE_W-1:0] lim;
    logic [POS_W:0]              pos_inc;
    logic [msc_pkg::WEIGHT_W-1:0] weight;
    logic [3:0]                  digit;
    logic                        carry;
    logic                        step;

    assign q_ready = !out_valid_reg || m_ready;
    assign step    = q_valid && q_ready;

    assign dwell_eff = (dwell_ticks_reg == '0) ? msc_pkg::DWELL_W'(1) : dwell_ticks_reg;
    assign scans_eff = (scans_reg == '0) ? msc_pkg::SCANS_W'(1) : scans_reg;
    assign dwell_inc = dwell_cnt_reg + msc_pkg::DWELL_W'(1);
    assign scan_inc  = scan_cnt_reg + msc_pkg::SCANS_W'(1);
    assign pos_inc   = {1'b0, pos_reg} + (POS_W+1)'(1);

    always_comb begin
        if (wrap_reg == '0) begin
            lim = msc_pkg::VALUE_W'(1);
        end else if (wrap_reg > msc_pkg::VALUE_MAX) begin
            lim = msc_pkg::VALUE_MAX;
        end else begin
            lim = wrap_reg;
        end
    end

    always_comb begin
        carry = 1'b1;
        for (int i = 0; i < msc_pkg::BCD_DIGITS; i++) begin
            if (carry && bcd_reg[i] == 4'd9) begin
                bcd_inc[i] = 4'd0;
            end else begin
                bcd_inc[i] = bcd_reg[i] + {3'd0, carry};
                carry      = 1'b0;
            end
        end
    end

    always_comb begin
        value_next     = value_reg;
        bcd_next       = bcd_reg;
        pos_next       = pos_reg;
        dwell_cnt_next = dwell_cnt_reg;
        scan_cnt_next  = scan_cnt_reg;
        if (q_cmd.advance) begin
            dwell_cnt_next = dwell_inc;
            if (dwell_inc >= dwell_eff || dwell_inc == '0) begin
                dwell_cnt_next = '0;
                pos_next       = pos_inc[POS_W-1:0];
                if (pos_inc >= (POS_W+1)'(DIGIT_COUNT)) begin
                    pos_next      = '0;
                    scan_cnt_next = scan_inc;
                    if (scan_inc >= scans_eff || scan_inc == '0) begin
                        scan_cnt_next = '0;
                        if (value_reg >= lim) begin
                            value_next = msc_pkg::VALUE_W'(1);
                            bcd_next   = msc_pkg::bcd_t'(1);
                        end else begin
                            value_next = value_reg + msc_pkg::VALUE_W'(1);
                            bcd_next   = bcd_inc;
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        weight = msc_pkg::WEIGHT_W'(DIGIT_COUNT - 1) - msc_pkg::WEIGHT_W'(pos_next);
        if (weight < msc_pkg::WEIGHT_W'(msc_pkg::BCD_DIGITS)) begin
            digit = bcd_next[weight[1:0]];
        end else begin
            digit = 4'd0;
        end
        seg_next = msc_pkg::seg_font(digit);
        for (int b = 0; b < msc_pkg::EN_W; b++) begin
            en_next[b] = (weight != msc_pkg::WEIGHT_W'(b));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dwell_ticks_reg <= msc_pkg::DWELL_RESET;
            scans_reg       <= msc_pkg::SCANS_RESET;
            wrap_reg        <= msc_pkg::WRAP_RESET;
        end else if (cfg.valid) begin
            unique case (cfg.index)
                msc_pkg::REG_DWELL_TICKS:     dwell_ticks_reg <= cfg.data;
                msc_pkg::REG_SCANS_PER_VALUE: scans_reg <= cfg.data[msc_pkg::SCANS_W-1:0];
                msc_pkg::REG_WRAP_VALUE:      wrap_reg <= cfg.data[msc_pkg::VALUE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg     <= msc_pkg::VALUE_W'(1);
            bcd_reg       <= msc_pkg::bcd_t'(1);
            pos_reg       <= '0;
            dwell_cnt_reg <= '0;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (step) begin
                value_reg     <= value_next;
                bcd_reg       <= bcd_next;
                pos_reg       <= pos_next;
                dwell_cnt_reg <= dwell_cnt_next;
                scan_cnt_reg  <= scan_cnt_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            seg_reg   <= seg_next;
            en_reg    <= en_next;
            shown_reg <= value_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign segments       = seg_reg;
    assign digit_enable_n = en_reg;
    assign shown_value    = shown_reg;

endmodule

// ----- rtl/core/multiplexed_seven_segment_counter.sv -----
// Four-digit multiplexed seven-segment counter.
// s_* channel: one beat per clock tick slot; s_tdata[0] = 1 means a tick passed,
//   0 means hold. Every input beat yields exactly one output beat.
// m_* channel: segment pattern, active-low digit enables and the shown value,
//   all reflecting the state after that beat's tick was applied.
// cfg_* channel: register writes, always ready; 0 dwell_ticks, 1 scans_per_value,
//   2 wrap_value. Write only while no beat is in flight.
// Throughput: one beat per cycle while m_tready is high. An accepted beat passes
//   through the two-entry command queue and the output register of the scan unit to m_tvalid.
// Reset: value 1, thousands digit selected, counters cleared, registers at
//   500 / 10 / 9999, queue empty, m_tvalid low.
// Stall: while m_tready is low the output beat holds; the queue absorbs two more
//   beats, then s_tready drops until the receiver takes the output.
module multiplexed_seven_segment_counter #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [0] tick, [7:1] zero
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [31:0]                         m_tdata,   // [7:0] segments,
                                                           // [11:8] digit_enable_n,
                                                           // [25:12] shown_value
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [msc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [msc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    msc_pkg::cfg_wr_t            cfg;
    msc_pkg::cmd_t               q_cmd;
    logic                        q_valid;
    logic                        q_ready;
    logic [msc_pkg::SEG_W-1:0]   segments;
    logic [msc_pkg::EN_W-1:0]    digit_enable_n;
    logic [msc_pkg::VALUE_W-1:0] shown_value;

    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid && cfg_ready;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    msc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tick   (s_tdata[0]),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    msc_back #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_cmd          (q_cmd),
        .m_valid        (m_tvalid),
        .m_ready        (m_tready),
        .segments       (segments),
        .digit_enable_n (digit_enable_n),
        .shown_value    (shown_value)
    );

    assign m_tdata = {6'd0, shown_value, digit_enable_n, segments};

    a_one_digit_lit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($countones(~m_tdata[11:8]) <= 1))
        else $error("more than one digit enabled");

    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[25:12] != 14'd0 && m_tdata[25:12] <= msc_pkg::VALUE_MAX))
        else $error("shown value out of range");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (s_tready && !m_tvalid))
        else $error("channels not idle after reset");

endmodule

// ----- verif/multiplexed_seven_segment_counter_tb.sv -----
`timescale 1ns / 1ps

module multiplexed_seven_segment_counter_tb;

    localparam int DIGITS         = 4;
    localparam int LONG_HOLD      = 120;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_ITEMS   = 450;

    localparam logic [msc_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [1:0]                      LAST_POS   = 2'(DIGITS - 1);

    localparam logic [msc_pkg::SEG_W-1:0] FONT [10] = '{
        8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
    };

    typedef struct packed {
        logic [msc_pkg::SEG_W-1:0]   segments;
        logic [msc_pkg::EN_W-1:0]    enables_n;
        logic [msc_pkg::VALUE_W-1:0] shown;
    } display_beat_t;

    class scan_scoreboard;
        display_beat_t               expected_beats[$];
        int                          errors;
        logic [msc_pkg::DWELL_W-1:0] dwell_ticks;
        logic [msc_pkg::SCANS_W-1:0] scans_per_value;
        logic [msc_pkg::VALUE_W-1:0] wrap_value;
        logic [msc_pkg::VALUE_W-1:0] shown;
        logic [1:0]                  digit_pos;
        logic [msc_pkg::DWELL_W-1:0] dwell_cnt;
        logic [msc_pkg::SCANS_W-1:0] scan_cnt;

        function new();
            errors          = 0;
            dwell_ticks     = msc_pkg::DWELL_RESET;
            scans_per_value = msc_pkg::SCANS_RESET;
            wrap_value      = msc_pkg::WRAP_RESET;
            shown           = 14'd1;
            digit_pos       = 2'd0;
            dwell_cnt       = '0;
            scan_cnt        = '0;
        endfunction

        function void apply_register(logic [msc_pkg::CFG_INDEX_W-1:0] index,
                                     logic [msc_pkg::CFG_DATA_W-1:0] data);
            case (index)
                msc_pkg::REG_DWELL_TICKS:     dwell_ticks = data;
                msc_pkg::REG_SCANS_PER_VALUE: scans_per_value = data[msc_pkg::SCANS_W-1:0];
                msc_pkg::REG_WRAP_VALUE:      wrap_value = data[msc_pkg::VALUE_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_tick(logic tick);
            logic [msc_pkg::DWELL_W-1:0] dwell;
            logic [msc_pkg::SCANS_W-1:0] scans;
            logic [msc_pkg::VALUE_W-1:0] lim;
            logic [1:0]                  weight;
            int unsigned                 place;
            display_beat_t               beat;
            dwell = (dwell_ticks == '0) ? 16'd1 : dwell_ticks;
            scans = (scans_per_value == '0) ? 8'd1 : scans_per_value;
            if (tick) begin
                dwell_cnt = dwell_cnt + 16'd1;
                if (dwell_cnt >= dwell || dwell_cnt == '0) begin
                    dwell_cnt = '0;
                    if (digit_pos == LAST_POS) begin
                        digit_pos = 2'd0;
                        scan_cnt  = scan_cnt + 8'd1;
                        if (scan_cnt >= scans || scan_cnt == '0) begin
                            scan_cnt = '0;
                            lim = (wrap_value == '0) ? 14'd1 : wrap_value;
                            if (lim > msc_pkg::VALUE_MAX) lim = msc_pkg::VALUE_MAX;
                            shown = (shown >= lim) ? 14'd1 : shown + 14'd1;
                        end
                    end else begin
                        digit_pos = digit_pos + 2'd1;
                    end
                end
            end
            weight = LAST_POS - digit_pos;
            case (weight)
                2'd3:    place = 1000;
                2'd2:    place = 100;
                2'd1:    place = 10;
                default: place = 1;
            endcase
            beat.segments  = FONT[(int'(shown) / place) % 10];
            beat.enables_n = ~(4'b0001 << weight);
            beat.shown     = shown;
            expected_beats.push_back(beat);
        endfunction

        function void check_beat(logic [31:0] data);
            display_beat_t want;
            if (expected_beats.size() == 0) begin
                $error("unexpected output beat %h", data);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            if (data[7:0] !== want.segments) begin
                $error("segments: expected %h, actual %h", want.segments, data[7:0]);
                errors++;
            end
            if (data[11:8] !== want.enables_n) begin
                $error("digit_enable_n: expected %b, actual %b", want.enables_n, data[11:8]);
                errors++;
            end
            if (data[25:12] !== want.shown) begin
                $error("shown_value: expected %0d, actual %0d", want.shown, data[25:12]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata   = 8'd0;   // [0] tick, [7:1] zero
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [31:0]                     m_tdata;            // [7:0] segments,
                                                         // [11:8] digit_enable_n,
                                                         // [25:12] shown_value
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [msc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [msc_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    scan_scoreboard sb;
    bit             tx_idles     = 1'b1;
    bit             rx_stalls    = 1'b1;
    bit             hold_request = 1'b0;

    multiplexed_seven_segment_counter #(.DIGIT_COUNT(DIGITS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_tick(s_tdata[0]);
            if (m_tvalid && m_tready) sb.check_beat(m_tdata);
            if (cfg_valid && cfg_ready) sb.apply_register(cfg_index, cfg_data);
        end
    end

    initial begin : receiver
        int span;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_request = 1'b0;
            end else if (rx_stalls && $urandom_range(0, 4) == 0) begin
                span = $urandom_range(1, 11);
                m_tready <= 1'b0;
                repeat (span) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic send_tick(logic tick);
        int gap;
        if (tx_idles && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, tick};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic play_ticks(int count, int one_pct);
        for (int i = 0; i < count; i++)
            send_tick($urandom_range(0, 99) < one_pct);
        s_tvalid <= 1'b0;
    endtask

    task automatic put_register(logic [msc_pkg::CFG_INDEX_W-1:0] index,
                                logic [msc_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(logic [15:0] dwell, logic [7:0] scans, logic [15:0] wrap,
                             bit stray);
        wait_drained();
        put_register(msc_pkg::REG_DWELL_TICKS, dwell);
        put_register(msc_pkg::REG_SCANS_PER_VALUE, {8'd0, scans});
        put_register(msc_pkg::REG_WRAP_VALUE, wrap);
        if (stray) put_register(REG_UNUSED, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int          sent;
        int          count;
        logic [15:0] dwell;
        logic [7:0]  scans;
        logic [15:0] wrap;
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: hold and single ticks
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        s_tvalid <= 1'b0;

        // zero dwell and zero scans act as one, short wrap, unused index dropped
        configure(16'd0, 8'd0, 16'd3, 1'b1);
        play_ticks(10, 100);

        // zero wrap keeps the value at one
        configure(16'd1, 8'd1, 16'd0, 1'b0);
        send_tick(1'b0);
        play_ticks(5, 100);

        // wrap above the decimal range saturates, widest dwell and scans
        configure(16'hFFFF, 8'hFF, 16'h3FFF, 1'b0);
        play_ticks(3, 100);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 2))
                    0:       dwell = 16'hFFFF;
                    1:       dwell = 16'd0;
                    default: dwell = 16'($urandom);
                endcase
            end else begin
                dwell = 16'($urandom_range(0, 3));
            end
            if ($urandom_range(0, 4) == 0)
                scans = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'($urandom);
            else
                scans = 8'($urandom_range(0, 3));
            if ($urandom_range(0, 4) == 0)
                wrap = 16'($urandom);
            else
                wrap = 16'($urandom_range(0, 40));
            configure(dwell, scans, wrap, $urandom_range(0, 3) == 0);

            count = $urandom_range(30, 70);
            if (sent + count >= RANDOM_ITEMS - 60) begin
                // last stretch: both sides run flat out
                tx_idles  = 1'b0;
                rx_stalls = 1'b0;
                count     = RANDOM_ITEMS - sent;
            end else if (sent >= 150 && sent < 220) begin
                tx_idles     = 1'b0;
                rx_stalls    = 1'b1;
                hold_request = 1'b1;
                count        = 80;
            end else begin
                tx_idles  = ($urandom_range(0, 3) != 0);
                rx_stalls = ($urandom_range(0, 3) != 0);
            end
            play_ticks(count, $urandom_range(50, 95));
            sent += count;
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- multiplexed_seven_segment_counter.f -----
rtl/core/msc_pkg.sv
rtl/core/msc_front.sv
rtl/core/msc_back.sv
rtl/core/multiplexed_seven_segment_counter.sv
verif/multiplexed_seven_segment_counter_tb.sv
